FILE: design/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg: shared types and codes for the Cholesky linear solver
// Item structs, mode codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package cls_pkg;

   localparam logic [1:0] MODE_LOAD_A = 2'd0;
   localparam logic [1:0] MODE_LOAD_B = 2'd1;
   localparam logic [1:0] MODE_START  = 2'd2;

   localparam logic [0:0] REG_SIZE = 1'b0;
   localparam logic [0:0] REG_TOL  = 1'b1;

   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;

   typedef struct packed {
      logic [1:0]         mode;
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         solution_index;
      logic signed [31:0] solution_value;
      logic               status;
      logic               last;
   } rsp_type;

   // operation handed to the arithmetic cell chain
   typedef struct packed {
      logic               go;
      logic               is_sqrt;
      logic signed [63:0] num;
      logic signed [31:0] den;
   } op_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return S32_MAX;
      if (v < -64'sd2147483648) return S32_MIN;
      return v[31:0];
   endfunction

endpackage

FILE: design/cholesky_linear_solver.sv
// ----------------------------------------------------------------------------
// cholesky_linear_solver: Q16.16 solve of A*x = b by Cholesky factorization
//
//   channel  dir  handshake       payload
//   req_     in   valid / stall   cls_pkg::req_type
//   rsp_     out  valid / stall   cls_pkg::rsp_type
//   csr_     in   valid / ready   index, data
//
// Load items take one cycle each. A start item holds input for the factor and
// both substitutions: each divide or square root is fetched, issued and passed
// through the 32+FRAC_BITS cell chain, and each product term is read and then
// accumulated. Reset is synchronous and clears control only; stores are
// undefined until written. Results wait in an output register while rsp_stall
// is high.
// ----------------------------------------------------------------------------
module cholesky_linear_solver #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cls_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cls_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_data
);
   localparam int IW = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ACC  = 3'd1;
   localparam logic [2:0] ST_OP   = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;
   localparam logic [2:0] ST_FAIL = 3'd5;
   localparam logic [2:0] ST_FETCH= 3'd6;
   localparam logic [2:0] ST_RD   = 3'd7;

   localparam logic [1:0] PH_FACT = 2'd0;
   localparam logic [1:0] PH_FWD  = 2'd1;
   localparam logic [1:0] PH_BWD  = 2'd2;

   logic signed [31:0] mat_mem [DEPTH];
   logic signed [31:0] fac_mem [DEPTH];
   logic signed [31:0] rhs_mem [MAX_DIM];
   logic signed [31:0] wrk_mem [MAX_DIM];

   logic [3:0]         size_ff;
   logic signed [31:0] tol_ff;
   logic [2:0]         st_ff, st_in;
   logic [1:0]         ph_ff, ph_in;
   logic [IW:0]        n_ff;
   logic [IW-1:0]      i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               rv_ff;
   cls_pkg::rsp_type   rsp_ff;
   cls_pkg::op_type    op;
   logic               done;
   logic signed [31:0] result;
   logic signed [31:0] ra_ff, rb_ff, base_ff, den_ff;
   logic [AW-1:0]      a_addr, b_addr, base_addr, den_addr;
   logic signed [63:0] prod;
   logic               diag;
   logic               fail_now;

   function automatic logic [AW-1:0] mem_addr(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
      return AW'(int'(r) * MAX_DIM + int'(c));
   endfunction

   assign csr_ready = 1'b1;
   assign req_stall = (st_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 4'd8;
         tol_ff  <= 32'sd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            cls_pkg::REG_SIZE: size_ff <= csr_data[3:0];
            cls_pkg::REG_TOL:  tol_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         if (req_data.mode == cls_pkg::MODE_LOAD_A && 32'(req_data.row) < MAX_DIM &&
             32'(req_data.col) < MAX_DIM && req_data.col <= req_data.row)
            mat_mem[mem_addr(IW'(req_data.row), IW'(req_data.col))] <= req_data.value;
         if (req_data.mode == cls_pkg::MODE_LOAD_B && 32'(req_data.row) < MAX_DIM)
            rhs_mem[IW'(req_data.row)] <= req_data.value;
      end
   end

   // current target is (i,j): factor off-diagonal when j<i, diagonal when j==i
   always_comb begin
      diag      = (j_ff == i_ff);
      a_addr    = (ph_ff == PH_BWD) ? mem_addr(k_ff, i_ff) : mem_addr(i_ff, k_ff);
      b_addr    = mem_addr(j_ff, k_ff);
      base_addr = mem_addr(i_ff, j_ff);
      den_addr  = (ph_ff == PH_FACT) ? mem_addr(j_ff, j_ff) : mem_addr(i_ff, i_ff);
      prod      = (64'(ra_ff) * 64'(rb_ff)) >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_FETCH) begin
         den_ff <= fac_mem[den_addr];
         unique case (ph_ff)
            PH_FACT: base_ff <= mat_mem[base_addr];
            PH_FWD:  base_ff <= rhs_mem[i_ff];
            default: base_ff <= wrk_mem[i_ff];
         endcase
      end
      if (st_ff == ST_RD) begin
         ra_ff <= fac_mem[a_addr];
         if (ph_ff == PH_FACT) rb_ff <= fac_mem[b_addr];
         else rb_ff <= wrk_mem[k_ff];
      end
   end

   logic [IW:0] kstart, kend;
   logic        has_terms;
   always_comb begin
      unique case (ph_ff)
         PH_FACT: begin kstart = '0; kend = {1'b0, j_ff}; end
         PH_FWD:  begin kstart = '0; kend = {1'b0, i_ff}; end
         default: begin kstart = {1'b0, i_ff} + 1'b1; kend = n_ff; end
      endcase
      has_terms  = kstart < kend;
      op.num     = 64'(base_ff) - acc_ff;
      op.den     = den_ff;
      op.is_sqrt = (ph_ff == PH_FACT) && diag;
      fail_now   = (st_ff == ST_OP) && op.is_sqrt && (op.num < 64'(tol_ff));
      op.go      = (st_ff == ST_OP) && !fail_now;
   end

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      acc_in = acc_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_valid && req_data.mode == cls_pkg::MODE_START) begin
               st_in = ST_FETCH; ph_in = PH_FACT; i_in = '0; j_in = '0;
            end
         end
         ST_FETCH: begin
            acc_in = '0;
            k_in   = kstart[IW-1:0];
            st_in  = has_terms ? ST_RD : ST_OP;
         end
         ST_RD: begin
            st_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + prod;
            k_in   = k_ff + 1'b1;
            if ({1'b0, k_ff} + 1'b1 == kend) st_in = ST_OP;
            else st_in = ST_RD;
         end
         ST_OP: begin
            if (fail_now) st_in = ST_FAIL;
            else st_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (done) begin
               st_in = ST_FETCH;
               unique case (ph_ff)
                  PH_FACT: begin
                     if (!diag) j_in = j_ff + 1'b1;
                     else if ({1'b0, i_ff} + 1'b1 == n_ff) begin
                        ph_in = PH_FWD; i_in = '0;
                     end else begin
                        i_in = i_ff + 1'b1; j_in = '0;
                     end
                  end
                  PH_FWD: begin
                     if ({1'b0, i_ff} + 1'b1 == n_ff) begin
                        ph_in = PH_BWD; i_in = IW'(n_ff - 1'b1);
                     end else i_in = i_ff + 1'b1;
                  end
                  default: begin
                     if (i_ff == '0) begin st_in = ST_OUT; i_in = '0; end
                     else i_in = i_ff - 1'b1;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               if ({1'b0, i_ff} + 1'b1 == n_ff) st_in = ST_IDLE;
               else i_in = i_ff + 1'b1;
            end
         end
         ST_FAIL: begin
            if (!rv_ff || !rsp_stall) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ph_ff <= PH_FACT;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ph_ff <= ph_in;
         rv_ff <= ((st_ff == ST_OUT || st_ff == ST_FAIL) && (!rv_ff || !rsp_stall)) ||
                  (rv_ff && rsp_stall);
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      acc_ff <= acc_in;
      if (st_ff == ST_IDLE)
         n_ff <= (size_ff == 4'd0) ? (IW+1)'(1) :
                 (32'(size_ff) > MAX_DIM) ? (IW+1)'(MAX_DIM) : (IW+1)'(size_ff);
      if (st_ff == ST_WAIT && done) begin
         unique case (ph_ff)
            PH_FACT: fac_mem[mem_addr(i_ff, j_ff)] <= result;
            default: wrk_mem[i_ff] <= result;
         endcase
      end
      if (st_ff == ST_OUT && (!rv_ff || !rsp_stall)) begin
         rsp_ff.solution_index <= 3'(i_ff);
         rsp_ff.solution_value <= wrk_mem[i_ff];
         rsp_ff.status         <= 1'b0;
         rsp_ff.last           <= ({1'b0, i_ff} + 1'b1 == n_ff);
      end
      if (st_ff == ST_FAIL && (!rv_ff || !rsp_stall)) begin
         rsp_ff <= '{solution_index: 3'd0, solution_value: 32'sd0, status: 1'b1, last: 1'b1};
      end
   end

   cls_chain #(.FRAC_BITS(FRAC_BITS)) u_chain (
      .clock(clock), .reset(reset), .op(op), .done(done), .result(result)
   );

`ifndef NO_ASSERTIONS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> req_stall) else $error("input open while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled item changed");
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      done |-> (st_ff == ST_WAIT)) else $error("chain result without wait");
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> rsp_data.last) else $error("fail not last");
`endif
endmodule

FILE: design/cls_cell.sv
// ----------------------------------------------------------------------------
// cls_cell: one bit step of the shared divide / square-root chain
// Restoring step on a partial remainder, passed to the next cell each cycle.
// ----------------------------------------------------------------------------
module cls_cell #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic         in_sqrt,
   input  logic [W-1:0] in_rem,
   input  logic [W-1:0] in_root,
   input  logic [W-1:0] in_bit,
   input  logic [W-1:0] in_den,
   input  logic [W-1:0] in_quo,
   output logic         out_valid,
   output logic         out_sqrt,
   output logic [W-1:0] out_rem,
   output logic [W-1:0] out_root,
   output logic [W-1:0] out_bit,
   output logic [W-1:0] out_den,
   output logic [W-1:0] out_quo
);
   logic         valid_ff, sqrt_ff;
   logic [W-1:0] rem_ff, root_ff, bit_ff, den_ff, quo_ff;
   logic [W-1:0] rem_in, root_in, bit_in, den_in, quo_in;
   logic [W-1:0] trial;

   always_comb begin
      rem_in  = in_rem;
      root_in = in_root;
      quo_in  = in_quo;
      den_in  = in_den;
      bit_in  = in_bit;
      trial   = in_root + in_bit;
      if (in_sqrt) begin
         // hold the root once every bit is spent
         if (in_bit != '0) begin
            bit_in = in_bit >> 2;
            if (in_rem >= trial) begin
               rem_in  = in_rem - trial;
               root_in = (in_root >> 1) + in_bit;
            end else begin
               root_in = in_root >> 1;
            end
         end
      end else begin
         den_in = in_den >> 1;
         bit_in = in_bit >> 1;
         if (in_rem >= in_den) begin
            rem_in = in_rem - in_den;
            quo_in = in_quo | in_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      sqrt_ff <= in_sqrt;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign out_valid = valid_ff;
   assign out_sqrt  = sqrt_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_bit   = bit_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
endmodule

FILE: design/cls_chain.sv
// ----------------------------------------------------------------------------
// cls_chain: row of bit cells computing saturated Q division or square root
// One cell per quotient bit; a result is registered in each cell in turn and leaves the last.
// ----------------------------------------------------------------------------
module cls_chain #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cls_pkg::op_type    op,
   output logic               done,
   output logic signed [31:0] result
);
   localparam int W      = 64 + FRAC_BITS;
   localparam int NCELL  = 32 + FRAC_BITS;
   localparam int SQ_TOP = ((30 + FRAC_BITS) / 2) * 2;

   logic         v   [NCELL+1];
   logic         sq  [NCELL+1];
   logic [W-1:0] rem [NCELL+1];
   logic [W-1:0] rt  [NCELL+1];
   logic [W-1:0] bt  [NCELL+1];
   logic [W-1:0] dn  [NCELL+1];
   logic [W-1:0] qu  [NCELL+1];

   logic signed [31:0] nsat;
   logic [W-1:0]       nabs, dabs;
   logic               neg_in, zero_in, pos_in;
   logic [NCELL-1:0]   neg_ff, zero_ff, numpos_ff;
   logic [NCELL-1:0]   neg_in_v, zero_in_v, numpos_in_v;

   always_comb begin
      nsat    = cls_pkg::sat32(op.num);
      nabs    = W'(nsat[31] ? -$signed({{32{nsat[31]}}, nsat}) : {32'd0, nsat});
      dabs    = W'(op.den[31] ? -$signed({{32{op.den[31]}}, op.den}) : {32'd0, op.den});
      neg_in  = nsat[31] ^ op.den[31];
      zero_in = (op.den == 32'sd0);
      pos_in  = (nsat > 32'sd0);
      v[0]  = op.go;
      sq[0] = op.is_sqrt;
      rt[0] = '0;
      qu[0] = '0;
      if (op.is_sqrt) begin
         rem[0] = pos_in ? (W'(nsat) << FRAC_BITS) : '0;
         bt[0]  = W'(1) << SQ_TOP;
         dn[0]  = '0;
      end else begin
         rem[0] = nabs << FRAC_BITS;
         bt[0]  = W'(1) << (NCELL - 1);
         dn[0]  = dabs << (NCELL - 1);
      end
   end

   genvar g;
   generate
      for (g = 0; g < NCELL; g++) begin : g_cell
         cls_cell #(.W(W)) u_cell (
            .clock(clock), .reset(reset),
            .in_valid(v[g]), .in_sqrt(sq[g]), .in_rem(rem[g]), .in_root(rt[g]),
            .in_bit(bt[g]), .in_den(dn[g]), .in_quo(qu[g]),
            .out_valid(v[g+1]), .out_sqrt(sq[g+1]), .out_rem(rem[g+1]),
            .out_root(rt[g+1]), .out_bit(bt[g+1]), .out_den(dn[g+1]), .out_quo(qu[g+1])
         );
      end
   endgenerate

   always_comb begin
      neg_in_v    = {neg_ff[NCELL-2:0], neg_in};
      zero_in_v   = {zero_ff[NCELL-2:0], zero_in};
      numpos_in_v = {numpos_ff[NCELL-2:0], ~nsat[31]};
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in_v;
      zero_ff   <= zero_in_v;
      numpos_ff <= numpos_in_v;
   end

   logic signed [W-1:0] sq_q;
   always_comb begin
      done = v[NCELL];
      sq_q = neg_ff[NCELL-1] ? -$signed(qu[NCELL]) : $signed(qu[NCELL]);
      if (sq[NCELL]) result = cls_pkg::sat32(64'(rt[NCELL]));
      else if (zero_ff[NCELL-1])
         result = numpos_ff[NCELL-1] ? cls_pkg::S32_MAX : cls_pkg::S32_MIN;
      else result = cls_pkg::sat32(64'(sq_q));
   end
endmodule
